// File: src/fpd_pkg.sv
// Shared types and constants for the flow path distance block.
// No dependencies; imported by fpd_walk_seq and the top level.
package fpd_pkg;

    // Table depth and the widths that follow from it
    localparam int MAX_CELLS = 64;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);

    // Field widths
    localparam int ID_W   = 32;
    localparam int STEP_W = 32;
    localparam int DIST_W = 38;
    // A walk adds at most MAX_CELLS + 1 steps, so this sum never wraps
    localparam int SUM_W  = STEP_W + CNT_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_CELLS);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Walk status codes
    typedef enum logic [1:0] {
        WS_OK        = 2'd0,
        WS_NOT_FOUND = 2'd1,
        WS_TOO_LONG  = 2'd2
    } t_walk_status;

    // One stored cell: its id, its downslope id and its step distance
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   ds_id;
        logic [STEP_W-1:0] step;
    } t_cell_entry;

    localparam int ENTRY_W = $bits(t_cell_entry);

    // Cell memory access from the sequencer
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        t_cell_entry       wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

// File: src/fpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fpd_walk_seq.sv
// Load and walk sequencer: stores cells, then walks each downslope chain
// with a one-entry-per-cycle scan of the cell memory. Uses fpd_pkg.
module fpd_walk_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [fpd_pkg::ID_W-1:0] i_outlet_id,
    // Cell load channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [fpd_pkg::ID_W-1:0]   i_cell_id,
    input  logic [fpd_pkg::ID_W-1:0]   i_downslope_cell_id,
    input  logic [fpd_pkg::STEP_W-1:0] i_step_distance,
    input  logic                       i_last_cell,
    // Cell memory
    output fpd_pkg::t_mem_req          o_mem_req,
    input  fpd_pkg::t_cell_entry       i_mem_rdata,
    // Result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fpd_pkg::ID_W-1:0]   o_result_cell_id,
    output logic [fpd_pkg::DIST_W-1:0] o_outlet_distance,
    output logic [1:0]                 o_walk_status,
    output logic                       o_last_result
);

    import fpd_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_START,
        S_CHECK,
        S_SEARCH,
        S_WAIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_probe;
    logic [CNT_W-1:0]  r_hops;
    logic [ID_W-1:0]   r_cur;
    logic [SUM_W-1:0]  r_sum;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_cell_id;
    logic [DIST_W-1:0] r_dist;
    t_walk_status      r_status;
    logic              r_last;

    logic              in_accept;
    logic              cur_is_outlet;
    logic              probe_hit;
    logic              probe_end;
    logic              k_is_last;
    logic [DIST_W-1:0] sum_sat;

    assign in_accept     = i_in_valid && (r_state == S_LOAD);
    assign cur_is_outlet = (r_cur == i_outlet_id);
    assign probe_hit     = (i_mem_rdata.id == r_cur);
    assign probe_end     = ({1'b0, r_probe} == (r_count - CNT_W'(1)));
    assign k_is_last     = ({1'b0, r_k} == (r_count - CNT_W'(1)));
    assign sum_sat       = (r_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : r_sum[DIST_W-1:0];

    // Memory requests: load writes, fetch of the walked cell, scan probes
    always_comb begin
        o_mem_req.we          = in_accept && (r_count < CNT_MAX);
        o_mem_req.waddr       = r_count[IDX_W-1:0];
        o_mem_req.wdata.id    = i_cell_id;
        o_mem_req.wdata.ds_id = i_downslope_cell_id;
        o_mem_req.wdata.step  = i_step_distance;
        unique case (r_state)
            S_CHECK:  o_mem_req.raddr = '0;
            S_SEARCH: o_mem_req.raddr = r_probe + IDX_W'(1);
            default:  o_mem_req.raddr = r_k;
        endcase
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_accept) begin
                        if (r_count < CNT_MAX) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_last_cell) begin
                            r_k     <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_cell_id <= i_mem_rdata.id;
                    if (i_mem_rdata.id == i_outlet_id) begin
                        r_dist      <= '0;
                        r_status    <= WS_OK;
                        r_last      <= k_is_last;
                        r_out_valid <= 1'b1;
                        r_state     <= S_WAIT;
                    end else begin
                        r_sum   <= SUM_W'(i_mem_rdata.step);
                        r_cur   <= i_mem_rdata.ds_id;
                        r_hops  <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (cur_is_outlet) begin
                        r_dist      <= sum_sat;
                        r_status    <= WS_OK;
                        r_last      <= k_is_last;
                        r_out_valid <= 1'b1;
                        r_state     <= S_WAIT;
                    end else if (r_hops >= r_count) begin
                        r_dist      <= '0;
                        r_status    <= WS_TOO_LONG;
                        r_last      <= k_is_last;
                        r_out_valid <= 1'b1;
                        r_state     <= S_WAIT;
                    end else begin
                        // probe of entry 0 is issued this cycle
                        r_probe <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // data on the memory port belongs to r_probe
                    if (probe_hit) begin
                        r_sum   <= r_sum + SUM_W'(i_mem_rdata.step);
                        r_cur   <= i_mem_rdata.ds_id;
                        r_hops  <= r_hops + CNT_W'(1);
                        r_state <= S_CHECK;
                    end else if (probe_end) begin
                        r_dist      <= '0;
                        r_status    <= WS_NOT_FOUND;
                        r_last      <= k_is_last;
                        r_out_valid <= 1'b1;
                        r_state     <= S_WAIT;
                    end else begin
                        r_probe <= r_probe + IDX_W'(1);
                    end
                end
                S_WAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_LOAD);
    assign o_out_valid       = r_out_valid;
    assign o_result_cell_id  = r_cell_id;
    assign o_outlet_distance = r_dist;
    assign o_walk_status     = r_status;
    assign o_last_result     = r_last;

    // A result is only shown while the sequencer waits for it to be taken
    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_WAIT))
        else $error("result valid outside the wait state");

    // A stored cell that does not start the walks bumps the count by one
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_last_cell && (r_count < CNT_MAX))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("load count did not advance");

    // Taking the final result returns the block to loading with an empty table
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last && !i_out_stall)
        |=> ((r_state == S_LOAD) && (r_count == '0)))
        else $error("walks did not finish cleanly");

    // Probes stay inside the loaded part of the table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ({1'b0, r_probe} < r_count))
        else $error("probe beyond loaded cells");

endmodule

// File: src/flow_path_distance_to_outlet.sv
// Top level of the flow path distance block: outlet register, cell memory
// and walk sequencer. Depends on fpd_pkg, fpd_ram and fpd_walk_seq.

// Cells of one subbasin are loaded one request per cycle (up to MAX_CELLS
// stored; extra cells are dropped). The request with last_cell set starts the
// walks, and the load channel stalls until the final result has been taken.
// Each stored cell then gets one result in load order. Per cell the walk
// fetches the cell (S_FETCH, S_START), then per hop takes one check and a
// scan of up to n entries (n = cells loaded), and ends with the result
// handshake. The walk time is set by the single read port of the cell
// memory, which the id search scans one entry per cycle. The outlet id
// register may be written only while the block is loading and no walk is
// pending.
module flow_path_distance_to_outlet (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Outlet id register write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fpd_pkg::ID_W-1:0]   i_outlet_cell_id,
    // Cell load channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [fpd_pkg::ID_W-1:0]   i_cell_id,
    input  logic [fpd_pkg::ID_W-1:0]   i_downslope_cell_id,
    input  logic [fpd_pkg::STEP_W-1:0] i_step_distance,
    input  logic                       i_last_cell,
    // Result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fpd_pkg::ID_W-1:0]   o_result_cell_id,
    output logic [fpd_pkg::DIST_W-1:0] o_outlet_distance,
    output logic [1:0]                 o_walk_status,
    output logic                       o_last_result
);

    import fpd_pkg::*;

    logic [ID_W-1:0] r_outlet_id;
    t_mem_req        mem_req;
    t_cell_entry     mem_rdata;

    // Outlet id register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outlet_id <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_outlet_id <= i_outlet_cell_id;
        end
    end

    // Cell memory: id, downslope id and step per entry
    fpd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Load and walk sequencer
    fpd_walk_seq u_walk_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_outlet_id         (r_outlet_id),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cell_id           (i_cell_id),
        .i_downslope_cell_id (i_downslope_cell_id),
        .i_step_distance     (i_step_distance),
        .i_last_cell         (i_last_cell),
        .o_mem_req           (mem_req),
        .i_mem_rdata         (mem_rdata),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_cell_id    (o_result_cell_id),
        .o_outlet_distance   (o_outlet_distance),
        .o_walk_status       (o_walk_status),
        .o_last_result       (o_last_result)
    );

endmodule
